>>> design/qsfs_pkg.sv
// Package for the query string field splitter.
// Holds the word types, widths, byte codes and queue sizes that the modules share.
// Depends on nothing.
package qsfs_pkg;

   // Limits of one query.
   localparam int MAX_FIELDS      = 32;
   localparam int MAX_QUERY_BYTES = 4096;
   localparam int POS_W           = $clog2(MAX_QUERY_BYTES + 1);

   // Field widths of the words on the ports.
   localparam int LIMIT_W     = 6;
   localparam int FIELD_IDX_W = 5;
   localparam int OFFSET_W    = 12;
   localparam int LENGTH_W    = 13;
   localparam int TOTAL_W     = 6;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

   // Byte codes that steer the parser.
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_AMP    = 8'h26;
   localparam logic [7:0] CHR_EQUALS = 8'h3D;

   // Byte classes handed from the front to the back.
   localparam int CLS_W = 2;
   localparam logic [CLS_W-1:0] CLS_OTHER  = 2'd0;
   localparam logic [CLS_W-1:0] CLS_EQUALS = 2'd1;
   localparam logic [CLS_W-1:0] CLS_AMP    = 2'd2;
   localparam logic [CLS_W-1:0] CLS_TERM   = 2'd3;

   // Queue sizes.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = CMD_PTR_W + 1;
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic                   field_valid;
      logic [FIELD_IDX_W-1:0] field_index;
      logic [OFFSET_W-1:0]    name_offset;
      logic [LENGTH_W-1:0]    name_length;
      logic                   has_value;
      logic [OFFSET_W-1:0]    value_offset;
      logic [LENGTH_W-1:0]    value_length;
      logic                   end_of_query;
      logic [TOTAL_W-1:0]     total_fields;
      logic                   overflow;
   } rsp_word_type;

   // A classified byte as it waits between front and back.
   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic             is_last;
   } cmd_type;

   // Map a raw byte onto its parser class.
   function automatic logic [CLS_W-1:0] classify(input logic [7:0] b);
      logic [CLS_W-1:0] c;
      if (b == CHR_NUL || b == CHR_LF || b == CHR_CR) begin
         c = CLS_TERM;
      end else if (b == CHR_EQUALS) begin
         c = CLS_EQUALS;
      end else if (b == CHR_AMP) begin
         c = CLS_AMP;
      end else begin
         c = CLS_OTHER;
      end
      return c;
   endfunction

endpackage

>>> design/qsfs_front.sv
// Front end of the query string field splitter.
// Accepts raw bytes, classifies them and keeps them in a short command queue.
// Depends on qsfs_pkg.
module qsfs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  qsfs_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   output qsfs_pkg::cmd_type     cmd_word,
   input  logic                  cmd_pop
);
   import qsfs_pkg::*;

   cmd_type              cmd_mem [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 push;
   cmd_type              new_cmd;

   // A word is taken whenever the queue has a free slot.
   assign req_full  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign push      = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_word  = cmd_mem[rd_ptr_ff];

   // Classify the incoming byte on its way into the queue.
   always_comb begin
      new_cmd.cls     = classify(req_word.data_byte);
      new_cmd.is_last = req_word.is_last;
   end

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> design/qsfs_back.sv
// Back end of the query string field splitter.
// Runs the parse state per classified byte, builds result words and queues them.
// Depends on qsfs_pkg.
module qsfs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [qsfs_pkg::LIMIT_W-1:0]  csr_wdata,
   input  logic                          cmd_valid,
   input  qsfs_pkg::cmd_type             cmd_word,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output qsfs_pkg::rsp_word_type        rsp_word
);
   import qsfs_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_NAME  = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // Parse state.
   logic [1:0]         phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   name_start_ff, name_start_in;
   logic [POS_W-1:0]   name_bytes_ff, name_bytes_in;
   logic [POS_W-1:0]   value_start_ff, value_start_in;
   logic [TOTAL_W-1:0] fields_ff, fields_in;
   logic               overflow_ff, overflow_in;
   logic [LIMIT_W-1:0] limit_ff;

   // Step logic.
   logic [1:0]         ph_open;
   logic               in_range;
   logic               want_now, value_now;
   logic               want_end, value_end;
   logic               want, is_value, rec_ok, emit, fire;
   logic [LIMIT_W-1:0] limit_act;
   logic [POS_W-1:0]   sel_end, sel_ns, sel_nb, sel_vs;
   logic [POS_W-1:0]   name_len, value_len;
   rsp_word_type       new_rsp;

   // Result queue.
   rsp_word_type         rsp_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 rsp_full, rsp_push, rsp_take;

   assign rsp_full  = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_word  = rsp_mem[rd_ptr_ff];

   // A byte is carried out when the result queue could take a word.
   assign fire     = cmd_valid && (!rsp_full || rsp_take);
   assign cmd_pop  = fire;
   assign rsp_push = fire && emit;

   // Limits above the field table size act as the table size.
   assign limit_act = (limit_ff > LIMIT_W'(MAX_FIELDS)) ? LIMIT_W'(MAX_FIELDS) : limit_ff;

   // Next parse state for the byte at the head of the command queue.
   always_comb begin
      in_range       = (pos_ff < POS_W'(MAX_QUERY_BYTES));
      ph_open        = (phase_ff == PH_IDLE) ? PH_NAME : phase_ff;
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      name_start_in  = name_start_ff;
      name_bytes_in  = name_bytes_ff;
      value_start_in = value_start_ff;
      want_now       = 1'b0;
      value_now      = 1'b0;
      if (in_range) begin
         pos_in = pos_ff + 1'b1;
         if (phase_ff != PH_DONE) begin
            unique case (cmd_word.cls)
               CLS_TERM: begin
                  want_now  = (phase_ff == PH_NAME) || (phase_ff == PH_VALUE);
                  value_now = (phase_ff == PH_VALUE);
                  phase_in  = PH_DONE;
               end
               CLS_EQUALS: begin
                  if (ph_open == PH_NAME) begin
                     name_bytes_in  = pos_ff - name_start_ff;
                     value_start_in = pos_ff + 1'b1;
                     phase_in       = PH_VALUE;
                  end else begin
                     phase_in = ph_open;
                  end
               end
               CLS_AMP: begin
                  want_now      = 1'b1;
                  value_now     = (ph_open == PH_VALUE);
                  name_start_in = pos_ff + 1'b1;
                  phase_in      = PH_NAME;
               end
               CLS_OTHER: begin
                  phase_in = ph_open;
               end
            endcase
         end
      end
   end

   // At the last byte an open field closes, but a field with an empty name and no value does not count.
   always_comb begin
      want_end  = cmd_word.is_last && !want_now &&
                  (((phase_in == PH_NAME) && (pos_in > name_start_in)) ||
                   (phase_in == PH_VALUE));
      value_end = (phase_in == PH_VALUE);
   end

   // Pick the operands of the field being closed and work out its lengths.
   always_comb begin
      if (want_now) begin
         sel_end  = pos_ff;
         sel_ns   = name_start_ff;
         sel_nb   = name_bytes_ff;
         sel_vs   = value_start_ff;
         is_value = value_now;
      end else begin
         sel_end  = pos_in;
         sel_ns   = name_start_in;
         sel_nb   = name_bytes_in;
         sel_vs   = value_start_in;
         is_value = value_end;
      end
      want      = want_now || want_end;
      rec_ok    = want && (fields_ff < limit_act);
      name_len  = is_value ? sel_nb : sel_end - sel_ns;
      value_len = sel_end - sel_vs;
      emit      = rec_ok || cmd_word.is_last;
      fields_in = fields_ff + TOTAL_W'(rec_ok);
      overflow_in = overflow_ff || !in_range || (want && !rec_ok);
   end

   // Build the result word; unused fields read as zero.
   always_comb begin
      new_rsp              = '0;
      new_rsp.field_valid  = rec_ok;
      new_rsp.end_of_query = cmd_word.is_last;
      new_rsp.total_fields = fields_in;
      new_rsp.overflow     = overflow_in;
      if (rec_ok) begin
         new_rsp.field_index = fields_ff[FIELD_IDX_W-1:0];
         new_rsp.name_offset = sel_ns[OFFSET_W-1:0];
         new_rsp.name_length = LENGTH_W'(name_len);
         if (is_value) begin
            new_rsp.has_value    = 1'b1;
            new_rsp.value_offset = sel_vs[OFFSET_W-1:0];
            new_rsp.value_length = LENGTH_W'(value_len);
         end
      end
   end

   // Parse state and limit register. The last byte clears the query.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pos_ff         <= '0;
         name_start_ff  <= '0;
         name_bytes_ff  <= '0;
         value_start_ff <= '0;
         fields_ff      <= '0;
         overflow_ff    <= 1'b0;
         limit_ff       <= LIMIT_RESET;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (fire) begin
            if (cmd_word.is_last) begin
               phase_ff       <= PH_IDLE;
               pos_ff         <= '0;
               name_start_ff  <= '0;
               name_bytes_ff  <= '0;
               value_start_ff <= '0;
               fields_ff      <= '0;
               overflow_ff    <= 1'b0;
            end else begin
               phase_ff       <= phase_in;
               pos_ff         <= pos_in;
               name_start_ff  <= name_start_in;
               name_bytes_ff  <= name_bytes_in;
               value_start_ff <= value_start_in;
               fields_ff      <= fields_in;
               overflow_ff    <= overflow_in;
            end
         end
      end
   end

   // Result queue pointers and fill count.
   assign count_in = count_ff + RSP_CNT_W'(rsp_push) - RSP_CNT_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (rsp_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Result storage needs no reset.
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_mem[wr_ptr_ff] <= new_rsp;
      end
   end

endmodule

>>> design/query_string_field_splitter_core.sv
// Top level of the query string field splitter.
// Connects the classifying front end and the parsing back end; depends on qsfs_pkg,
// qsfs_front and qsfs_back.
//
// Usage:
// The byte channel is a queue input: a word (data_byte, is_last) is taken at a clock
// edge where req_push is high and req_full is low. The result channel is a queue
// output: the oldest result word sits on rsp_word while rsp_empty is low and leaves
// at an edge where rsp_pop is high. A byte gives one result word when it closes a
// field within the limit or when it is the last byte of the query.
// csr_we writes csr_wdata into the field limit; write it only while the block is idle.
// A byte is first registered in the command queue; its result word is then registered
// in the result queue and shows on rsp_word from there.
// Throughput: one byte per cycle while the result queue has room or is being popped,
// set by the parse state update in the back end. A four-entry command queue sits
// between front and back, and a two-entry result queue sits at the output, so the
// input keeps flowing while a result waits. When the receiver stalls, the result
// queue fills, then the command queue, and req_full rises; no word is lost.
// Reset clears both queues and the parse state and sets the field limit to 32.
module query_string_field_splitter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  qsfs_pkg::req_word_type        req_word,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output qsfs_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_we,
   input  logic [qsfs_pkg::LIMIT_W-1:0]  csr_wdata
);
   import qsfs_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_word;

   // Classify and buffer incoming bytes.
   qsfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop)
   );

   // Parse the classified bytes and queue the results.
   qsfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

>>> design/qsfs_checker.sv
// Port checker for the query string field splitter, with its bind statement.
// Watches the top level's ports only; depends on qsfs_pkg and the top level.
module qsfs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input qsfs_pkg::rsp_word_type        rsp_word
);
   import qsfs_pkg::*;

   // Reset leaves both queues empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting result word stays put until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("result word changed while stalled");

   // A field's ordinal is below the running field count.
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.field_valid |-> rsp_word.field_index < rsp_word.total_fields)
      else $error("field index not below field count");

   // The field count never passes the table size.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word.total_fields <= TOTAL_W'(MAX_FIELDS))
      else $error("field count above table size");

   // A field without a value carries a zero value span.
   a_no_value: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_word.has_value |->
         rsp_word.value_offset == '0 && rsp_word.value_length == '0)
      else $error("value span set without a value");

endmodule

bind query_string_field_splitter_core qsfs_checker u_checker (.*);
